### src/tsss_pkg.sv
// ----------------------------------------------------------------------------
// tsss_pkg
// shared widths, command codes and config register indexes for the throttle
// soft start / stop sequencer
// ----------------------------------------------------------------------------
package tsss_pkg;

  localparam int LEVEL_W = 16;
  localparam int DELAY_W = 20;
  localparam int TIME_W  = 32;
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LEVEL_W;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [DELAY_W-1:0] delay_t;
  typedef logic [TIME_W-1:0]  stamp_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STARTUP_STEP  = 2'd0,
    CFG_VALVE_STEP    = 2'd1,
    CFG_SHUTOFF_LEVEL = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

  localparam level_t STARTUP_STEP_RST  = LEVEL_W'(655);
  localparam level_t VALVE_STEP_RST    = LEVEL_W'(328);
  localparam level_t SHUTOFF_LEVEL_RST = LEVEL_W'(6554);

endpackage

### src/tsss_if.sv
// ----------------------------------------------------------------------------
// tsss_in_if / tsss_out_if
// valid/ready channels for command items and throttle results
// ----------------------------------------------------------------------------
interface tsss_in_if;
  import tsss_pkg::*;

  logic   valid;
  logic   ready;
  logic [CMD_W-1:0] cmd;
  delay_t delay_ticks;
  level_t throttle_request;

  modport source (output valid, output cmd, output delay_ticks, output throttle_request,
                  input ready);
  modport sink   (input valid, input cmd, input delay_ticks, input throttle_request,
                  output ready);
endinterface

interface tsss_out_if;
  import tsss_pkg::*;

  logic   valid;
  logic   ready;
  level_t throttle_level;
  logic   is_firing;
  logic   is_starting;
  logic   is_stopping;

  modport source (output valid, output throttle_level, output is_firing, output is_starting,
                  output is_stopping, input ready);
  modport sink   (input valid, input throttle_level, input is_firing, input is_starting,
                  input is_stopping, output ready);
endinterface

### src/throttle_soft_start_stop_sequencer_core.sv
// ----------------------------------------------------------------------------
// throttle_soft_start_stop_sequencer_core
// flow: the input register loads at the transfer; the state update and result
//   register load follow when the item advances, held while a result stalls
// throughput: one item per cycle unless output stalls; input register refills
//   while a result waits; state advances only when the result register is free
// reset: synchronous active-low rst_n clears valids, flags, throttle, tick
//   counter, stamps and waits, and loads the config register defaults
// ----------------------------------------------------------------------------
module throttle_soft_start_stop_sequencer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  tsss_in_if.sink                          in_ch,
  tsss_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [tsss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tsss_pkg::*;

  // config
  level_t startup_step_r, valve_step_r, shutoff_level_r;

  // input register
  logic   in_valid_r;
  cmd_t   cmd_r;
  delay_t delay_r;
  level_t req_r;

  // state, also the result register
  logic   out_valid_r;
  level_t throttle_r, throttle_nxt;
  logic   firing_r, firing_nxt;
  logic   starting_r, starting_nxt;
  logic   stopping_r, stopping_nxt;
  stamp_t tick_count_r, tick_count_nxt;
  stamp_t start_stamp_r, start_stamp_nxt;
  delay_t start_wait_r, start_wait_nxt;
  stamp_t stop_stamp_r, stop_stamp_nxt;
  delay_t stop_wait_r, stop_wait_nxt;

  logic   advance;
  stamp_t now;
  stamp_t start_elapsed, stop_elapsed;
  logic   start_due, stop_due;
  logic [LEVEL_W:0] up_sum;
  level_t up_sat, down_sat, req_diff, follow_lvl;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_step_r  <= STARTUP_STEP_RST;
      valve_step_r    <= VALVE_STEP_RST;
      shutoff_level_r <= SHUTOFF_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STARTUP_STEP:  startup_step_r  <= cfg_data;
        CFG_VALVE_STEP:    valve_step_r    <= cfg_data;
        CFG_SHUTOFF_LEVEL: shutoff_level_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      cmd_r   <= cmd_t'(in_ch.cmd);
      delay_r <= in_ch.delay_ticks;
      req_r   <= in_ch.throttle_request;
    end
  end

  // tick datapath
  assign now           = tick_count_r + TIME_W'(1);
  assign start_elapsed = now - start_stamp_r;
  assign stop_elapsed  = now - stop_stamp_r;
  assign start_due     = start_elapsed > TIME_W'(start_wait_r);
  assign stop_due      = stop_elapsed > TIME_W'(stop_wait_r);
  assign up_sum        = {1'b0, throttle_r} + {1'b0, startup_step_r};
  assign up_sat        = up_sum[LEVEL_W] ? {LEVEL_W{1'b1}} : up_sum[LEVEL_W-1:0];
  assign down_sat      = (throttle_r > startup_step_r) ? throttle_r - startup_step_r
                                                       : '0;
  assign req_diff      = (req_r >= throttle_r) ? req_r - throttle_r : throttle_r - req_r;

  always_comb begin
    if (req_diff < valve_step_r) begin
      follow_lvl = req_r;
    end else if (req_r >= throttle_r) begin
      follow_lvl = throttle_r + valve_step_r;
    end else begin
      follow_lvl = throttle_r - valve_step_r;
    end
  end

  always_comb begin
    throttle_nxt    = throttle_r;
    firing_nxt      = firing_r;
    starting_nxt    = starting_r;
    stopping_nxt    = stopping_r;
    tick_count_nxt  = tick_count_r;
    start_stamp_nxt = start_stamp_r;
    start_wait_nxt  = start_wait_r;
    stop_stamp_nxt  = stop_stamp_r;
    stop_wait_nxt   = stop_wait_r;
    case (cmd_r)
      CMD_TICK: begin
        tick_count_nxt = now;
        if (starting_r && start_due) begin
          firing_nxt = 1'b1;
          if (throttle_r < req_r) begin
            throttle_nxt = up_sat;
          end else begin
            starting_nxt = 1'b0;
          end
        end else if (stopping_r && stop_due) begin
          if (throttle_r < shutoff_level_r) begin
            stopping_nxt = 1'b0;
            firing_nxt   = 1'b0;
          end else begin
            throttle_nxt = down_sat;
          end
        end else if (firing_r) begin
          throttle_nxt = follow_lvl;
        end
      end
      CMD_START: begin
        if (!starting_r && !firing_r) begin
          stopping_nxt    = 1'b0;
          starting_nxt    = 1'b1;
          throttle_nxt    = '0;
          start_wait_nxt  = delay_r;
          start_stamp_nxt = tick_count_r;
        end
      end
      CMD_STOP: begin
        if (starting_r || firing_r) begin
          starting_nxt   = 1'b0;
          stopping_nxt   = 1'b1;
          stop_wait_nxt  = delay_r;
          stop_stamp_nxt = tick_count_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      throttle_r    <= '0;
      firing_r      <= 1'b0;
      starting_r    <= 1'b0;
      stopping_r    <= 1'b0;
      tick_count_r  <= '0;
      start_stamp_r <= '0;
      start_wait_r  <= '0;
      stop_stamp_r  <= '0;
      stop_wait_r   <= '0;
    end else begin
      if (advance) begin
        out_valid_r   <= 1'b1;
        throttle_r    <= throttle_nxt;
        firing_r      <= firing_nxt;
        starting_r    <= starting_nxt;
        stopping_r    <= stopping_nxt;
        tick_count_r  <= tick_count_nxt;
        start_stamp_r <= start_stamp_nxt;
        start_wait_r  <= start_wait_nxt;
        stop_stamp_r  <= stop_stamp_nxt;
        stop_wait_r   <= stop_wait_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.throttle_level = throttle_r;
  assign out_ch.is_firing      = firing_r;
  assign out_ch.is_starting    = starting_r;
  assign out_ch.is_stopping    = stopping_r;

  a_phase_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(starting_r && stopping_r))
    else $error("starting and stopping both set");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(throttle_r) && $stable(tick_count_r) && $stable(firing_r))
    else $error("state changed without an item");

  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cmd_r == CMD_TICK |=> tick_count_r == $past(tick_count_r) + TIME_W'(1))
    else $error("tick counter did not advance on tick");

  a_start_arm: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cmd_r == CMD_START && !starting_r && !firing_r
    |=> starting_r && throttle_r == '0 && !stopping_r)
    else $error("start did not arm ramp-up");

  a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !advance)
    else $error("result overwritten while stalled");

endmodule
